FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the load-cell front end.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

FILE: rtl/core/lctca_pkg.sv
// Package for the load-cell tare, calibrate and stream front end.
// Holds widths, opcodes, modes and event codes; no dependencies.
package lctca_pkg;
    localparam int SAMPLE_BITS_D = 24;
    localparam int COUNT_BITS_D  = 8;
    localparam int MEAS_W        = 40;
    localparam int SCALE_W       = 32;
    localparam int MASS_W        = 24;
    localparam int ACC_W         = 48;
    localparam int DIV_W         = 64;

    localparam logic [2:0] OP_SAMPLE = 3'd0;
    localparam logic [2:0] OP_TICK   = 3'd1;
    localparam logic [2:0] OP_TARE   = 3'd2;
    localparam logic [2:0] OP_CALIB  = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;
    localparam logic [2:0] OP_STOP   = 3'd5;

    localparam logic [1:0] MODE_READY  = 2'd0;
    localparam logic [1:0] MODE_TARE   = 2'd1;
    localparam logic [1:0] MODE_CALIB  = 2'd2;
    localparam logic [1:0] MODE_STREAM = 2'd3;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TARE  = 2'd1;
    localparam logic [1:0] ERR_CALIB = 2'd2;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_TARE  = 2'd1;
    localparam logic [1:0] EV_CALIB = 2'd2;

    localparam logic [2:0] REG_AUTO   = 3'd0;
    localparam logic [2:0] REG_TSAMP  = 3'd1;
    localparam logic [2:0] REG_CSAMP  = 3'd2;
    localparam logic [2:0] REG_SSAMP  = 3'd3;
    localparam logic [2:0] REG_TTICKS = 3'd4;
    localparam logic [2:0] REG_CTICKS = 3'd5;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

FILE: rtl/core/lctca_div.sv
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on lctca_pkg and assert_macros.svh.
module lctca_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [lctca_pkg::DIV_W-1:0]    dividend,
    input  logic [lctca_pkg::DIV_W-1:0]    divisor,
    output lctca_pkg::div_ctl_t            ctl,
    output logic [lctca_pkg::DIV_W-1:0]    quotient
);
    import lctca_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] num_reg, num_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   shifted;

    always_comb
    begin
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DIV_W-1:0], num_reg[DIV_W-1]};
        trial     = shifted - {1'b0, den_reg};
        if (start)
        begin
            num_next  = dividend[DIV_W-1] ? (~dividend + 1'b1) : dividend;
            den_next  = divisor[DIV_W-1] ? (~divisor + 1'b1) : divisor;
            neg_next  = dividend[DIV_W-1] ^ divisor[DIV_W-1];
            rem_next  = '0;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift one dividend bit into the remainder, restore on underflow
            if (!trial[DIV_W])
            begin
                rem_next = trial;
                num_next = {num_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                num_next = {num_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign quotient  = neg_reg ? (~num_reg + 1'b1) : num_reg;
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    `include "assert_macros.svh"
    `CHK_NEXT(a_start_busy, start, busy_reg)
    `CHK_NEXT(a_done_ends_busy, busy_reg && cnt_reg == CNT_W'(1) && !start, done_reg && !busy_reg)
    `CHK_IMPL(a_not_both, done_reg, !busy_reg || $past(start))
endmodule

FILE: rtl/core/load_cell_tare_calibrate_average.sv
// Top level of the load-cell tare, calibrate and stream front end.
// Depends on lctca_pkg, lctca_div and assert_macros.svh.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_stall, opcode/sample/known_mass | request in
//  out     | out_valid, out_stall, mode..scale_now        | request out
//  cfg     | cfg_we, cfg_index, cfg_data                  | write only
//
// One request at a time: take it in idle, work it in the exec state, offer
// the result in the out state. A divider pass yields all 64 quotient bits.
// A sample that closes a tare or stream average runs one pass, every stream
// sample at nonzero scale one ahead, and calibration two (one at zero mass).
// Reset sets mode, counters and state at once to listed values, not payloads.
// A stalled result holds in the output register; the next request is taken
// only once that result has left.
module load_cell_tare_calibrate_average
#(
    parameter int SAMPLE_BITS = lctca_pkg::SAMPLE_BITS_D,
    parameter int COUNT_BITS  = lctca_pkg::COUNT_BITS_D
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     opcode,
    input  logic signed [SAMPLE_BITS-1:0]  sample,
    input  logic [lctca_pkg::MASS_W-1:0]   known_mass,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     mode,
    output logic                           accepted,
    output logic                           meas_valid,
    output logic signed [lctca_pkg::MEAS_W-1:0] measurement,
    output logic [1:0]                     error_code,
    output logic [1:0]                     cal_event,
    output logic signed [SAMPLE_BITS-1:0]  offset_now,
    output logic signed [lctca_pkg::SCALE_W-1:0] scale_now,
    input  logic                           cfg_we,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_data
);
    import lctca_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_DIV1 = 5'b00100,
        ST_DIV2 = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    localparam logic signed [DIV_W-1:0] SC_MAX = DIV_W'(64'sd2147483647);
    localparam logic signed [DIV_W-1:0] SC_MIN = -DIV_W'(64'sd2147483648);
    localparam logic signed [DIV_W-1:0] MS_MAX = DIV_W'(64'sd549755813887);
    localparam logic signed [DIV_W-1:0] MS_MIN = -DIV_W'(64'sd549755813888);
    localparam logic [COUNT_BITS-1:0]   CMAX   = '1;

    state_t st_reg, st_next;

    // configuration
    logic        auto_reg;
    logic [7:0]  tsamp_reg, csamp_reg, ssamp_reg;
    logic [15:0] tticks_reg, cticks_reg;

    // block state
    logic [1:0]                    mode_reg, mode_next;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic [COUNT_BITS-1:0]         cnt_reg, cnt_next;
    logic [15:0]                   ticks_reg, ticks_next;
    logic signed [SAMPLE_BITS-1:0] offset_reg, offset_next;
    logic signed [SCALE_W-1:0]     scale_reg, scale_next;
    logic [MASS_W-1:0]             mass_reg, mass_next;

    // held request
    logic [2:0]                    op_reg;
    logic signed [SAMPLE_BITS-1:0] smp_reg;
    logic [MASS_W-1:0]             km_reg;

    // result fields
    logic       acc_flag_reg, acc_flag_next;
    logic       mv_reg, mv_next;
    logic signed [MEAS_W-1:0] meas_reg, meas_next;
    logic [1:0] err_reg, err_next;
    logic [1:0] ev_reg, ev_next;

    // divider
    logic                div_start;
    logic [DIV_W-1:0]    div_a, div_b, div_q;
    div_ctl_t            div_ctl;
    logic [1:0]          div_kind_reg, div_kind_next; // which division is running

    logic [COUNT_BITS-1:0]     need;
    logic [COUNT_BITS-1:0]     cnt_inc;
    logic signed [DIV_W-1:0]   diff;
    logic signed [DIV_W-1:0]   q_s;
    logic signed [DIV_W-1:0]   acc_sum;

    lctca_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .ctl      (div_ctl),
        .quotient (div_q)
    );

    function automatic logic [COUNT_BITS-1:0] eff(input logic [7:0] n);
        logic [COUNT_BITS-1:0] r;
        if (n == 8'd0)
            r = COUNT_BITS'(1);
        else if ({24'd0, n} > 32'(CMAX))
            r = CMAX;
        else
            r = COUNT_BITS'(n);
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg   <= 1'b0;
            tsamp_reg  <= 8'd16;
            csamp_reg  <= 8'd16;
            ssamp_reg  <= 8'd4;
            tticks_reg <= 16'd1000;
            cticks_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AUTO:   auto_reg   <= cfg_data[0];
                REG_TSAMP:  tsamp_reg  <= cfg_data[7:0];
                REG_CSAMP:  csamp_reg  <= cfg_data[7:0];
                REG_SSAMP:  ssamp_reg  <= cfg_data[7:0];
                REG_TTICKS: tticks_reg <= cfg_data;
                REG_CTICKS: cticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_stall = (st_reg != ST_IDLE);
    assign q_s      = $signed(div_q);
    assign cnt_inc  = cnt_reg + 1'b1;
    assign diff     = DIV_W'(smp_reg) - DIV_W'(offset_reg);

    always_comb
    begin
        case (mode_reg)
            MODE_TARE:  need = eff(tsamp_reg);
            MODE_CALIB: need = eff(csamp_reg);
            default:    need = eff(ssamp_reg);
        endcase
    end

    always_comb
    begin
        st_next       = st_reg;
        mode_next     = mode_reg;
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        ticks_next    = ticks_reg;
        offset_next   = offset_reg;
        scale_next    = scale_reg;
        mass_next     = mass_reg;
        acc_flag_next = acc_flag_reg;
        mv_next       = mv_reg;
        meas_next     = meas_reg;
        err_next      = err_reg;
        ev_next       = ev_reg;
        div_start     = 1'b0;
        div_a         = '0;
        div_b         = '0;
        div_kind_next = div_kind_reg;
        acc_sum       = '0;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    st_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                acc_flag_next = 1'b0;
                mv_next       = 1'b0;
                meas_next     = '0;
                err_next      = ERR_NONE;
                ev_next       = EV_NONE;
                st_next       = ST_OUT;
                case (op_reg)
                    OP_SAMPLE:
                    begin
                        if (mode_reg == MODE_TARE)
                        begin
                            acc_sum  = DIV_W'(acc_reg) + DIV_W'(smp_reg);
                            acc_next = ACC_W'(acc_sum);
                            cnt_next = cnt_inc;
                            if (cnt_inc >= need)
                            begin
                                div_start     = 1'b1;
                                div_a         = acc_sum;
                                div_b         = DIV_W'(cnt_inc);
                                div_kind_next = MODE_TARE;
                                st_next       = ST_DIV2;
                            end
                        end
                        else if (mode_reg == MODE_CALIB)
                        begin
                            acc_sum  = DIV_W'(acc_reg) + diff;
                            acc_next = ACC_W'(acc_sum);
                            cnt_next = cnt_inc;
                            if (cnt_inc >= need)
                            begin
                                div_start     = 1'b1;
                                div_a         = acc_sum;
                                div_b         = DIV_W'(cnt_inc);
                                div_kind_next = MODE_CALIB;
                                st_next       = ST_DIV1;
                            end
                        end
                        else if (mode_reg == MODE_STREAM)
                        begin
                            if (scale_reg == '0)
                            begin
                                // zero scale: saturate by sign of the difference
                                acc_sum = DIV_W'(acc_reg) + ((diff > 0) ? MS_MAX :
                                          ((diff < 0) ? MS_MIN : '0));
                                acc_next = ACC_W'(acc_sum);
                                cnt_next = cnt_inc;
                                if (cnt_inc >= need)
                                begin
                                    div_start     = 1'b1;
                                    div_a         = acc_sum;
                                    div_b         = DIV_W'(cnt_inc);
                                    div_kind_next = MODE_READY;
                                    st_next       = ST_DIV2;
                                end
                            end
                            else
                            begin
                                div_start     = 1'b1;
                                div_a         = diff <<< 24;
                                div_b         = DIV_W'(scale_reg);
                                div_kind_next = MODE_STREAM;
                                st_next       = ST_DIV1;
                            end
                        end
                    end
                    OP_TICK:
                    begin
                        if (mode_reg == MODE_TARE || mode_reg == MODE_CALIB)
                        begin
                            if (ticks_reg <= 16'd1)
                            begin
                                err_next   = (mode_reg == MODE_TARE) ? ERR_TARE : ERR_CALIB;
                                ticks_next = '0;
                                mode_next  = auto_reg ? MODE_STREAM : MODE_READY;
                                acc_next   = '0;
                                cnt_next   = '0;
                            end
                            else
                                ticks_next = ticks_reg - 1'b1;
                        end
                    end
                    OP_TARE, OP_CALIB:
                    begin
                        if (mode_reg == MODE_STREAM || mode_reg == MODE_READY)
                        begin
                            acc_next      = '0;
                            cnt_next      = '0;
                            acc_flag_next = 1'b1;
                            if (op_reg == OP_TARE)
                            begin
                                ticks_next = tticks_reg;
                                mode_next  = MODE_TARE;
                            end
                            else
                            begin
                                mass_next  = km_reg;
                                ticks_next = cticks_reg;
                                mode_next  = MODE_CALIB;
                            end
                        end
                    end
                    OP_START:
                    begin
                        if (mode_reg == MODE_READY)
                        begin
                            acc_next      = '0;
                            cnt_next      = '0;
                            mode_next     = MODE_STREAM;
                            acc_flag_next = 1'b1;
                        end
                    end
                    OP_STOP:
                    begin
                        if (mode_reg == MODE_STREAM)
                        begin
                            mode_next     = MODE_READY;
                            acc_flag_next = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_DIV1:
            begin
                // first division done: calib mean or per-sample mass
                if (div_ctl.done)
                begin
                    if (div_kind_reg == MODE_CALIB)
                    begin
                        if (mass_reg == '0)
                        begin
                            scale_next = q_s[DIV_W-1] ? SCALE_W'(SC_MIN) : SCALE_W'(SC_MAX);
                            ev_next    = EV_CALIB;
                            mode_next  = auto_reg ? MODE_STREAM : MODE_READY;
                            acc_next   = '0;
                            cnt_next   = '0;
                            st_next    = ST_OUT;
                        end
                        else
                        begin
                            div_start = 1'b1;
                            div_a     = q_s <<< 16;
                            div_b     = DIV_W'(mass_reg);
                            st_next   = ST_DIV2;
                        end
                    end
                    else
                    begin
                        acc_sum  = DIV_W'(acc_reg) + ((q_s > MS_MAX) ? MS_MAX :
                                   ((q_s < MS_MIN) ? MS_MIN : q_s));
                        acc_next = ACC_W'(acc_sum);
                        cnt_next = cnt_inc;
                        if (cnt_inc >= need)
                        begin
                            div_start     = 1'b1;
                            div_a         = acc_sum;
                            div_b         = DIV_W'(cnt_inc);
                            div_kind_next = MODE_READY;
                            st_next       = ST_DIV2;
                        end
                        else
                            st_next = ST_OUT;
                    end
                end
            end
            ST_DIV2:
            begin
                if (div_ctl.done)
                begin
                    st_next = ST_OUT;
                    if (div_kind_reg == MODE_TARE)
                    begin
                        offset_next = SAMPLE_BITS'(q_s);
                        ev_next     = EV_TARE;
                        mode_next   = auto_reg ? MODE_STREAM : MODE_READY;
                        acc_next    = '0;
                        cnt_next    = '0;
                    end
                    else if (div_kind_reg == MODE_CALIB)
                    begin
                        scale_next = (q_s > SC_MAX) ? SCALE_W'(SC_MAX) :
                                     ((q_s < SC_MIN) ? SCALE_W'(SC_MIN) : SCALE_W'(q_s));
                        ev_next    = EV_CALIB;
                        mode_next  = auto_reg ? MODE_STREAM : MODE_READY;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        meas_next = MEAS_W'(q_s);
                        mv_next   = 1'b1;
                        acc_next  = '0;
                        cnt_next  = '0;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            mode_reg     <= MODE_READY;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            ticks_reg    <= '0;
            offset_reg   <= '0;
            scale_reg    <= SCALE_W'(256);
            mass_reg     <= MASS_W'(256);
            div_kind_reg <= MODE_READY;
        end
        else
        begin
            st_reg       <= st_next;
            mode_reg     <= mode_next;
            acc_reg      <= acc_next;
            cnt_reg      <= cnt_next;
            ticks_reg    <= ticks_next;
            offset_reg   <= offset_next;
            scale_reg    <= scale_next;
            mass_reg     <= mass_next;
            div_kind_reg <= div_kind_next;
        end
    end

    // hold the request and result payloads
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            op_reg  <= opcode;
            smp_reg <= sample;
            km_reg  <= known_mass;
        end
        acc_flag_reg <= acc_flag_next;
        mv_reg       <= mv_next;
        meas_reg     <= meas_next;
        err_reg      <= err_next;
        ev_reg       <= ev_next;
    end

    assign out_valid   = (st_reg == ST_OUT);
    assign mode        = mode_reg;
    assign accepted    = acc_flag_reg;
    assign meas_valid  = mv_reg;
    assign measurement = meas_reg;
    assign error_code  = err_reg;
    assign cal_event   = ev_reg;
    assign offset_now  = offset_reg;
    assign scale_now   = scale_reg;

    `include "assert_macros.svh"
    `CHK_IMPL(a_out_no_in, out_valid, in_stall)
    `CHK_IMPL(a_mv_stream, out_valid && meas_valid, mode_reg == MODE_STREAM)
    `CHK_IMPL(a_div_idle, st_reg == ST_IDLE || st_reg == ST_OUT, !div_ctl.busy)
endmodule
